// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks the consequent in the same cycle as the antecedent.
`define RTE12_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rte12 assertion failed");

// Checks the consequent in the cycle after the antecedent.
`define RTE12_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rte12 assertion failed");

`endif

// ===== src/rte12_pkg.sv =====
`default_nettype none

package rte12_pkg;

    localparam int ResW     = 40;
    localparam int NumOrder = 11;
    localparam int NumThr   = 11;
    localparam int NumE12   = 12;
    localparam int NumBound = 10;

    typedef logic [ResW-1:0] res_t;
    typedef logic [3:0]      order_t;
    typedef logic [3:0]      idx_t;

    localparam res_t ResMax = 40'd999999999999;
    localparam res_t OutMax = 40'd820000000000;
    localparam order_t MaxOrder = 4'd10;
    localparam idx_t MaxIdx = 4'd11;

    typedef res_t [NumThr-1:0]   thr_row_t;
    typedef thr_row_t [NumOrder-1:0] thr_tab_t;
    typedef res_t [NumE12-1:0]   out_row_t;
    typedef out_row_t [NumOrder-1:0] out_tab_t;
    typedef res_t [NumBound-1:0] bound_tab_t;

    // Smallest leading part at which the next larger E12 entry wins (ties go up).
    localparam logic [6:0] ThrLead [NumThr] = '{
        7'd11, 7'd14, 7'd17, 7'd20, 7'd25, 7'd30, 7'd36, 7'd43, 7'd52, 7'd62, 7'd75
    };

    localparam logic [6:0] E12Lead [NumE12] = '{
        7'd10, 7'd12, 7'd15, 7'd18, 7'd22, 7'd27, 7'd33, 7'd39, 7'd47, 7'd56, 7'd68, 7'd82
    };

    // Value k gives the least value with k plus three decimal digits.
    localparam bound_tab_t OrderBound = '{
        40'd100000000000, 40'd10000000000, 40'd1000000000, 40'd100000000,
        40'd10000000, 40'd1000000, 40'd100000, 40'd10000, 40'd1000, 40'd100
    };

    function automatic thr_tab_t build_thr_tab();
        thr_tab_t    t;
        logic [63:0] p;
        logic [63:0] prod;
        p = 64'd1;
        for (int k = 0; k < NumOrder; k++) begin
            for (int j = 0; j < NumThr; j++) begin
                prod = 64'(ThrLead[j]) * p;
                t[k][j] = prod[ResW-1:0];
            end
            p = p * 64'd10;
        end
        return t;
    endfunction

    function automatic out_tab_t build_out_tab();
        out_tab_t    t;
        logic [63:0] p;
        logic [63:0] prod;
        p = 64'd1;
        for (int k = 0; k < NumOrder; k++) begin
            for (int j = 0; j < NumE12; j++) begin
                prod = 64'(E12Lead[j]) * p;
                t[k][j] = prod[ResW-1:0];
            end
            p = p * 64'd10;
        end
        return t;
    endfunction

    localparam thr_tab_t ThrTab = build_thr_tab();
    localparam out_tab_t OutTab = build_out_tab();

    typedef struct packed {
        res_t   value;
        order_t order;
    } ord_item_t;

endpackage

`default_nettype wire

// ===== src/rte12_order.sv =====
`default_nettype none
`include "assert_macros.svh"

module rte12_order (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  rte12_pkg::res_t       in_value,
    output logic                  out_valid,
    input  wire                   out_ready,
    output rte12_pkg::ord_item_t  out_item
);

    logic                 clamp_vld_reg, clamp_vld_next;
    rte12_pkg::res_t      clamp_val_reg, clamp_val_next;
    logic                 ord_vld_reg, ord_vld_next;
    rte12_pkg::ord_item_t ord_item_reg, ord_item_next;
    logic                 clamp_ready;
    logic                 ord_ready;
    rte12_pkg::order_t    order_cnt;

    assign ord_ready   = !ord_vld_reg || out_ready;
    assign clamp_ready = !clamp_vld_reg || ord_ready;
    assign in_ready    = clamp_ready;

    always_comb begin
        clamp_vld_next = clamp_vld_reg;
        clamp_val_next = clamp_val_reg;
        if (clamp_ready) begin
            clamp_vld_next = in_valid;
            clamp_val_next = (in_value > rte12_pkg::ResMax) ? rte12_pkg::ResMax : in_value;
        end
    end

    // The order is the number of decade bounds that the value reaches.
    always_comb begin
        order_cnt = '0;
        for (int k = 0; k < rte12_pkg::NumBound; k++) begin
            order_cnt = order_cnt +
                rte12_pkg::order_t'(clamp_val_reg >= rte12_pkg::OrderBound[k]);
        end
    end

    always_comb begin
        ord_vld_next  = ord_vld_reg;
        ord_item_next = ord_item_reg;
        if (ord_ready) begin
            ord_vld_next        = clamp_vld_reg;
            ord_item_next.value = clamp_val_reg;
            ord_item_next.order = order_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clamp_vld_reg <= 1'b0;
            ord_vld_reg   <= 1'b0;
        end else begin
            clamp_vld_reg <= clamp_vld_next;
            ord_vld_reg   <= ord_vld_next;
        end
        clamp_val_reg <= clamp_val_next;
        ord_item_reg  <= ord_item_next;
    end

    assign out_valid = ord_vld_reg;
    assign out_item  = ord_item_reg;

    `RTE12_ASSERT_NOW(a_clamp_range, aclk, aresetn, clamp_vld_reg,
        clamp_val_reg <= rte12_pkg::ResMax)
    `RTE12_ASSERT_NOW(a_order_small, aclk, aresetn, ord_vld_reg && ord_item_reg.order == '0,
        ord_item_reg.value < rte12_pkg::OrderBound[0])
    `RTE12_ASSERT_NEXT(a_order_load, aclk, aresetn, clamp_vld_reg && ord_ready,
        ord_vld_reg && ord_item_reg.value == $past(clamp_val_reg))

endmodule

`default_nettype wire

// ===== src/rte12_pick.sv =====
`default_nettype none
`include "assert_macros.svh"

module rte12_pick (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  rte12_pkg::ord_item_t  in_item,
    output logic                  out_valid,
    input  wire                   out_ready,
    output rte12_pkg::res_t       out_value
);

    logic                  sel_vld_reg, sel_vld_next;
    rte12_pkg::idx_t       sel_idx_reg, sel_idx_next;
    rte12_pkg::order_t     sel_ord_reg, sel_ord_next;
    logic                  res_vld_reg, res_vld_next;
    rte12_pkg::res_t       res_val_reg, res_val_next;
    logic                  sel_ready;
    logic                  res_ready;
    rte12_pkg::thr_row_t   thr_row;
    rte12_pkg::idx_t       idx_cnt;

    assign res_ready = !res_vld_reg || out_ready;
    assign sel_ready = !sel_vld_reg || res_ready;
    assign in_ready  = sel_ready;

    // Comparing the full value against the scaled thresholds avoids forming the
    // leading digits: the floor of value over the scale reaches a threshold
    // exactly when the value reaches the scaled threshold.
    always_comb begin
        thr_row = rte12_pkg::ThrTab[in_item.order];
        idx_cnt = '0;
        for (int j = 0; j < rte12_pkg::NumThr; j++) begin
            idx_cnt = idx_cnt + rte12_pkg::idx_t'(in_item.value >= thr_row[j]);
        end
    end

    always_comb begin
        sel_vld_next = sel_vld_reg;
        sel_idx_next = sel_idx_reg;
        sel_ord_next = sel_ord_reg;
        if (sel_ready) begin
            sel_vld_next = in_valid;
            sel_idx_next = idx_cnt;
            sel_ord_next = in_item.order;
        end
    end

    always_comb begin
        res_vld_next = res_vld_reg;
        res_val_next = res_val_reg;
        if (res_ready) begin
            res_vld_next = sel_vld_reg;
            res_val_next = rte12_pkg::OutTab[sel_ord_reg][sel_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            sel_vld_reg <= sel_vld_next;
            res_vld_reg <= res_vld_next;
        end
        sel_idx_reg <= sel_idx_next;
        sel_ord_reg <= sel_ord_next;
        res_val_reg <= res_val_next;
    end

    assign out_valid = res_vld_reg;
    assign out_value = res_val_reg;

    `RTE12_ASSERT_NOW(a_order_in_range, aclk, aresetn, in_valid,
        in_item.order <= rte12_pkg::MaxOrder)
    `RTE12_ASSERT_NOW(a_index_in_range, aclk, aresetn, sel_vld_reg,
        sel_idx_reg <= rte12_pkg::MaxIdx && sel_ord_reg <= rte12_pkg::MaxOrder)
    `RTE12_ASSERT_NOW(a_result_range, aclk, aresetn, res_vld_reg,
        res_val_reg <= rte12_pkg::OutMax && res_val_reg >= rte12_pkg::res_t'(10))

endmodule

`default_nettype wire

// ===== src/round_to_nearest_e12.sv =====
// Rounds a resistance to the nearest E12 preferred value, one transfer per cycle.
// Pipeline: four register stages (clamp, decade count, threshold compare, table lookup);
// an accepted input transfer passes through them in that order before m_tvalid rises.
// Throughput: one item per cycle; each stage holds its item while the next is full.
// Reset: aresetn low at a clock edge clears every stage valid bit; data registers are not reset.
`default_nettype none

module round_to_nearest_e12 (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [39:0]  s_tdata,   // [39:0] resistance
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [39:0]  m_tdata    // [39:0] rounded_resistance
);

    logic                 ord_valid;
    logic                 ord_ready;
    rte12_pkg::ord_item_t ord_item;
    rte12_pkg::res_t      res_value;

    rte12_order u_order (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .out_valid (ord_valid),
        .out_ready (ord_ready),
        .out_item  (ord_item)
    );

    rte12_pick u_pick (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ord_valid),
        .in_ready  (ord_ready),
        .in_item   (ord_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (res_value)
    );

    assign m_tdata = res_value;

endmodule

`default_nettype wire
